// ===== rtl/mmn_pkg.sv =====
// Shared constants and command codes for the min/max byte normalizer.
package mmn_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int QUOT_BITS   = 8;
  localparam int NUM_BITS    = SAMPLE_BITS + QUOT_BITS;
  localparam int STEP_BITS   = $clog2(QUOT_BITS);
  localparam int CMD_BITS    = 2;

  localparam logic [CMD_BITS-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_SCAN = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_NORM = 2'd2;

  localparam logic [QUOT_BITS-1:0] PIXEL_MAX = '1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } div_stat_t;

endpackage

// ===== rtl/mmn_div.sv =====
// Restoring divider: floor(255*(x-lo)/(hi-lo)), one quotient bit per cycle.
module mmn_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [mmn_pkg::SAMPLE_BITS-1:0] x,
  input  logic signed [mmn_pkg::SAMPLE_BITS-1:0] lo,
  input  logic signed [mmn_pkg::SAMPLE_BITS-1:0] hi,
  output mmn_pkg::div_stat_t                     stat
);
  import mmn_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_SCALE,
    D_STEP,
    D_FIN
  } dstate_t;

  dstate_t                state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] d_r, d_nxt;
  logic [SAMPLE_BITS-1:0] r_r, r_nxt;
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [QUOT_BITS-1:0]   nlo_r, nlo_nxt;
  logic [QUOT_BITS-1:0]   q_r, q_nxt;
  logic [STEP_BITS-1:0]   cnt_r, cnt_nxt;

  logic [NUM_BITS-1:0]    num;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;

  always_comb begin
    num   = {d_r, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, d_r};
    trial = {rem_r, nlo_r[QUOT_BITS-1]};
    diff  = trial - {1'b0, r_r};
    ge    = !diff[SAMPLE_BITS];

    state_nxt = state_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    rem_nxt   = rem_r;
    nlo_nxt   = nlo_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;

    case (state_r)
      D_IDLE: begin
        if (start) begin
          d_nxt     = SAMPLE_BITS'(x - lo);
          r_nxt     = SAMPLE_BITS'(hi - lo);
          state_nxt = D_SCALE;
        end
      end
      D_SCALE: begin
        rem_nxt   = num[NUM_BITS-1:QUOT_BITS];
        nlo_nxt   = num[QUOT_BITS-1:0];
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = D_STEP;
      end
      D_STEP: begin
        rem_nxt = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        nlo_nxt = {nlo_r[QUOT_BITS-2:0], 1'b0};
        q_nxt   = {q_r[QUOT_BITS-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_BITS'(QUOT_BITS - 1)) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    d_r   <= d_nxt;
    r_r   <= r_nxt;
    rem_r <= rem_nxt;
    nlo_r <= nlo_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.done = (state_r == D_FIN);
  assign stat.quot = q_r;

endmodule

// ===== rtl/minmax_normalize_to_byte.sv =====
// Top level of the min/max normalizer: command sequencer, running range and result register.
// Clear and scan transfers are absorbed in the cycle they are accepted and leave in_ready
// high. A normalize transfer yields one byte floor(255*(x-min)/(max-min)), saturated to
// 0 or 255 outside the scanned range, 0 with out_range_zero set when max equals min, and
// 0 when nothing was scanned since reset or clear. A sample strictly inside the range
// runs through the restoring divider, one quotient bit per cycle, in the steps classify
// and difference, scale by 255, eight divide steps, finish, result load; saturated and
// degenerate cases go from classify straight to result load. in_ready stays low
// from a normalize transfer until its result is loaded into the output register. Command 3
// is accepted and dropped.
module minmax_normalize_to_byte (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mmn_pkg::CMD_BITS-1:0]           in_cmd,
  input  logic signed [mmn_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [mmn_pkg::QUOT_BITS-1:0]          out_pixel,
  output logic                                   out_range_zero
);
  import mmn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASS,
    S_DIV,
    S_RESULT
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [QUOT_BITS-1:0]          pix_r, pix_nxt;
  logic                          rz_r, rz_nxt;
  logic [QUOT_BITS-1:0]          out_pixel_r, out_pixel_nxt;
  logic                          out_rz_r, out_rz_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic      in_xfer;
  logic      div_start;
  div_stat_t div_stat;

  mmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (x_r),
    .lo    (min_r),
    .hi    (max_r),
    .stat  (div_stat)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    x_nxt         = x_r;
    pix_nxt       = pix_r;
    rz_nxt        = rz_r;
    out_pixel_nxt = out_pixel_r;
    out_rz_nxt    = out_rz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_INIT: begin
              min_nxt = SAMPLE_POS_MAX;
              max_nxt = SAMPLE_NEG_MAX;
            end
            CMD_SCAN: begin
              if (in_sample < min_r) min_nxt = in_sample;
              if (in_sample > max_r) max_nxt = in_sample;
            end
            CMD_NORM: begin
              x_nxt     = in_sample;
              state_nxt = S_CLASS;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLASS: begin
        pix_nxt   = '0;
        rz_nxt    = 1'b0;
        state_nxt = S_RESULT;
        if (max_r == min_r) begin
          rz_nxt = 1'b1;
        end else if (max_r > min_r) begin
          if (x_r >= max_r) begin
            pix_nxt = PIXEL_MAX;
          end else if (x_r > min_r) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          pix_nxt   = div_stat.quot;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_pixel_nxt = pix_r;
          out_rz_nxt    = rz_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= SAMPLE_POS_MAX;
      max_r       <= SAMPLE_NEG_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r         <= x_nxt;
    pix_r       <= pix_nxt;
    rz_r        <= rz_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_rz_r    <= out_rz_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_range_zero = out_rz_r;

endmodule

// ===== rtl/mmn_chk.sv =====
// Port-level checker for the min/max normalizer, bound to the top level.
module mmn_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [mmn_pkg::CMD_BITS-1:0] in_cmd,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mmn_pkg::QUOT_BITS-1:0] out_pixel,
  input logic                         out_range_zero
);
  import mmn_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_range_zero))
    else $error("stalled result changed or dropped");

  a_rz_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_zero |-> out_pixel == '0)
    else $error("zero range with nonzero pixel");

  a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_NORM |=> !in_ready)
    else $error("ready right after normalize transfer");

  a_scan_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_INIT || in_cmd == CMD_SCAN) |=> in_ready)
    else $error("ready dropped after clear or scan transfer");

endmodule

bind minmax_normalize_to_byte mmn_chk u_mmn_chk (.*);

// ===== bench/pixel_checker.sv =====
// Checker for the min/max byte normalizer: tracks the scanned range, predicts bytes, compares.
`timescale 1ns / 1ps
module pixel_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [mmn_pkg::CMD_BITS-1:0]           in_cmd,
  input  logic signed [mmn_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [mmn_pkg::QUOT_BITS-1:0]          out_pixel,
  input  logic                                   out_range_zero,
  output int                                     n_pending,
  output int                                     n_fail,
  output int                                     n_bytes,
  output int                                     n_flat
);
  import mmn_pkg::*;

  typedef struct packed {
    logic [QUOT_BITS-1:0] pixel;
    logic                 range_zero;
  } pixel_t;

  pixel_t                        pixel_q[$];
  logic signed [SAMPLE_BITS-1:0] lo_seen;
  logic signed [SAMPLE_BITS-1:0] hi_seen;
  int                            fails;
  int                            bytes;
  int                            flats;

  function automatic pixel_t predict_pixel(input logic signed [SAMPLE_BITS-1:0] x);
    pixel_t r;
    longint num;
    longint span;
    r    = '0;
    num  = longint'(x) - longint'(lo_seen);
    span = longint'(hi_seen) - longint'(lo_seen);
    if (span == 0) begin
      r.range_zero = 1'b1;
    end else if (span > 0) begin
      if (num >= span) begin
        r.pixel = PIXEL_MAX;
      end else if (num > 0) begin
        r.pixel = QUOT_BITS'((num * longint'(PIXEL_MAX)) / span);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      pixel_q.delete();
      lo_seen = SAMPLE_POS_MAX;
      hi_seen = SAMPLE_NEG_MAX;
      fails   = 0;
      bytes   = 0;
      flats   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected transfer, pixel %0d range_zero %0b",
                     $time, out_pixel, out_range_zero);
          end
        end else begin
          want = pixel_q.pop_front();
          bytes++;
          if (want.range_zero) begin
            flats++;
          end
          if (out_pixel !== want.pixel || out_range_zero !== want.range_zero) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch, pixel exp %0d got %0d, range_zero exp %0b got %0b",
                       $time, want.pixel, out_pixel, want.range_zero, out_range_zero);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_INIT: begin
            lo_seen = SAMPLE_POS_MAX;
            hi_seen = SAMPLE_NEG_MAX;
          end
          CMD_SCAN: begin
            if (in_sample < lo_seen) begin
              lo_seen = in_sample;
            end
            if (in_sample > hi_seen) begin
              hi_seen = in_sample;
            end
          end
          CMD_NORM: begin
            pixel_q.push_back(predict_pixel(in_sample));
          end
          default: begin
          end
        endcase
      end
    end
    n_pending <= pixel_q.size();
    n_fail    <= fails;
    n_bytes   <= bytes;
    n_flat    <= flats;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the normalizer bench: clock, reset, command stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import mmn_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_DROP = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEM_TARGET    = 950;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic [CMD_BITS-1:0]           in_cmd    = CMD_INIT;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_ready = 1'b0;
  logic                          in_ready;
  logic                          out_valid;
  logic [QUOT_BITS-1:0]          out_pixel;
  logic                          out_range_zero;

  int n_pending;
  int n_fail;
  int n_bytes;
  int n_flat;
  int n_clear      = 0;
  int n_scan       = 0;
  int n_norm       = 0;
  int n_drop       = 0;
  int stall_cycles = 0;
  bit tx_calm      = 1'b0;

  always #2 clk = ~clk;

  minmax_normalize_to_byte dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_range_zero (out_range_zero)
  );

  pixel_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_range_zero (out_range_zero),
    .n_pending      (n_pending),
    .n_fail         (n_fail),
    .n_bytes        (n_bytes),
    .n_flat         (n_flat)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return SAMPLE_NEG_MAX + $urandom_range(0, 3);
      2:       return SAMPLE_POS_MAX - $urandom_range(0, 3);
      3:       return $urandom_range(0, 2000) - 1000;
      default: return $urandom_range(0, 32'hFFFF);
    endcase
  endfunction

  task automatic xfer(input logic [CMD_BITS-1:0] c, input logic [SAMPLE_BITS-1:0] s);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      tx_calm = !tx_calm;
    end
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= c;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    case (c)
      CMD_INIT: n_clear++;
      CMD_SCAN: n_scan++;
      CMD_NORM: n_norm++;
      default:  n_drop++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic run_sequence();
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] s;
    int unsigned            span;
    if ($urandom_range(0, 5) != 0) begin
      xfer(CMD_INIT, pick_sample());
    end
    base = pick_sample();
    case ($urandom_range(0, 3))
      0:       span = 0;
      1:       span = $urandom_range(1, 10);
      2:       span = $urandom_range(11, 100000);
      default: span = 32'hFFFF_FFFF;
    endcase
    repeat ($urandom_range(1, 8)) xfer(CMD_SCAN, base + $urandom_range(0, span));
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 7))
        0:       s = base - $urandom_range(0, 2);
        1:       s = base + span + $urandom_range(0, 2);
        2:       s = pick_sample();
        default: s = base + $urandom_range(0, span);
      endcase
      xfer(CMD_NORM, s);
    end
  endtask

  initial begin
    int gap;
    int got;
    bit calm;
    got  = 0;
    calm = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        calm = !calm;
      end
      gap = calm ? 0 : $urandom_range(0, 17);
      if (got == 60 || got == 250) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin
    int next_pause;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    xfer(CMD_NORM, 0);
    xfer(CMD_SCAN, 5);
    xfer(CMD_NORM, 5);
    xfer(CMD_NORM, -7);
    xfer(CMD_SCAN, SAMPLE_NEG_MAX);
    xfer(CMD_SCAN, SAMPLE_POS_MAX);
    xfer(CMD_NORM, SAMPLE_NEG_MAX);
    xfer(CMD_NORM, SAMPLE_POS_MAX);
    xfer(CMD_NORM, 0);
    xfer(CMD_NORM, -1);
    xfer(CMD_NORM, SAMPLE_POS_MAX - 1);
    xfer(CMD_DROP, 32'h5A5A_A5A5);
    xfer(CMD_NORM, 1);
    xfer(CMD_INIT, 32'hFFFF_FFFF);
    xfer(CMD_NORM, 0);
    xfer(CMD_SCAN, -100);
    xfer(CMD_SCAN, 100);
    xfer(CMD_NORM, -101);
    xfer(CMD_NORM, 101);
    xfer(CMD_NORM, -100);
    xfer(CMD_NORM, 100);
    xfer(CMD_NORM, 0);
    xfer(CMD_NORM, 99);
    xfer(CMD_INIT, 0);
    xfer(CMD_SCAN, -1);
    xfer(CMD_NORM, -1);
    drain();

    next_pause = n_clear + n_scan + n_norm + 100;
    while (n_clear + n_scan + n_norm < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) xfer(CMD_BITS'($urandom_range(0, 3)), pick_sample());
      end else begin
        run_sequence();
      end
      if (n_clear + n_scan + n_norm >= next_pause) begin
        drain();
        next_pause += 100 + $urandom_range(0, 100);
      end
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d clears, %0d scans, %0d normalizes, %0d unused commands;",
             n_clear, n_scan, n_norm, n_drop);
    $display("%0d bytes compared, %0d on a zero range, %0d errors.", n_bytes, n_flat, n_fail);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mmn_pkg.sv
rtl/mmn_div.sv
rtl/minmax_normalize_to_byte.sv
rtl/mmn_chk.sv
bench/pixel_checker.sv
bench/testbench.sv
